>>> design/scale_quantizer_semitone_unit_macros.svh
// Assertion macros for the scale quantizer semitone unit.
// Depends on nothing; included by the files that carry assertions.
`ifndef SCALE_QUANTIZER_SEMITONE_UNIT_MACROS_SVH
`define SCALE_QUANTIZER_SEMITONE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SQS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sqs: assertion failed");
// Next-cycle implication.
`define SQS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sqs: assertion failed");
`else
`define SQS_ASSERT_IMP(label, clk, rst, ante, cons)
`define SQS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/sqs_pkg.sv
// Shared constants and types for the scale quantizer semitone unit.
// No dependencies; used by sqs_mod_unit and the top level.
package sqs_pkg;

   // Scale geometry
   localparam int DEGREES_DEF = 12;
   localparam int TOGGLE_W    = 12;

   // Field widths
   localparam int SEMI_W  = 8;
   localparam int NOTE_W  = 9;
   localparam int OPND_W  = 9;
   localparam int MOD_STEPS = 7;

   // Quantize mode codes
   localparam int MODE_W = 3;
   localparam logic [MODE_W-1:0] MODE_HOLD     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CLOSE_UP = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CLOSE_DN = 3'd2;
   localparam logic [MODE_W-1:0] MODE_UP       = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DOWN     = 3'd4;

   // Register map
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NST  = 1'b1;

   typedef logic [NOTE_W-1:0]        note_type;
   typedef logic signed [OPND_W-1:0] opnd_type;

endpackage

>>> design/sqs_mod_unit.sv
// Floor-modulo reducer: maps a signed semitone operand onto 0..DEGREES-1.
// Depends on sqs_pkg; shared by the SETD, SETT, PD and TMP steps of the top-level sequencer.
module sqs_mod_unit #(
   parameter int DEGREES = sqs_pkg::DEGREES_DEF
) (
   input  sqs_pkg::opnd_type             operand,
   output logic [$clog2(DEGREES)-1:0]    degree
);

   localparam int DW     = $clog2(DEGREES);
   localparam int STEPS  = sqs_pkg::MOD_STEPS;
   localparam int HALF   = 2 ** (sqs_pkg::OPND_W - 1);
   localparam int OFFSET = DEGREES * ((HALF + DEGREES - 1) / DEGREES);
   localparam int XW     = $clog2(DEGREES * (2 ** STEPS)) + 1;

   logic [XW-1:0] rem_v;

   // Bias by a multiple of DEGREES to a positive value, then restoring reduction
   always_comb begin
      rem_v = XW'(int'(operand) + OFFSET);
      for (int k = STEPS - 1; k >= 0; k--) begin
         if (rem_v >= XW'(DEGREES << k)) begin
            rem_v = rem_v - XW'(DEGREES << k);
         end
      end
      degree = DW'(rem_v);
   end

endmodule

>>> design/scale_quantizer_semitone_unit.sv
// From the accepted request beat to the response beat a request passes through the degree
// steps (four steps through the shared modulo unit, the degree search loop, one response load).
// No new request is taken until the response register is loaded and the sequencer is idle again.
// A finished response waits in its output register while the next request is taken.
// Reset (synchronous, active high) clears the scale mask and last note and sets
// quantize_mode to 1 and note_set_transposed to 1.
`include "scale_quantizer_semitone_unit_macros.svh"

module scale_quantizer_semitone_unit #(
   parameter int DEGREES = sqs_pkg::DEGREES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [sqs_pkg::SEMI_W-1:0] req_pitch_semis,
   input  logic signed [sqs_pkg::SEMI_W-1:0] req_transpose_semis,
   input  logic [sqs_pkg::TOGGLE_W-1:0]      req_button_toggles,
   input  logic                              req_reset_edge,
   input  logic                              req_set_edge,
   input  logic signed [sqs_pkg::SEMI_W-1:0] req_set_note_semis,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [sqs_pkg::NOTE_W-1:0] rsp_note_out,
   output logic                              rsp_gate_on,
   output logic                              rsp_note_changed,
   output logic [sqs_pkg::TOGGLE_W-1:0]      rsp_scale_now,
   // configuration channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sqs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sqs_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int DW  = $clog2(DEGREES);
   localparam int NW  = sqs_pkg::NOTE_W;
   localparam int OW  = sqs_pkg::OPND_W;
   localparam int MW  = sqs_pkg::MODE_W;
   localparam int TW  = sqs_pkg::TOGGLE_W;
   localparam int SW  = sqs_pkg::SEMI_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SETD = 3'd1;
   localparam logic [2:0] S_SETT = 3'd2;
   localparam logic [2:0] S_PD   = 3'd3;
   localparam logic [2:0] S_TMP  = 3'd4;
   localparam logic [2:0] S_SRCH = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [MW-1:0]          mode_ff, mode_in;
   logic                   nst_ff, nst_in;
   logic [DEGREES-1:0]     mask_ff, mask_in;
   sqs_pkg::note_type      last_ff, last_in;
   logic [SW-1:0]          pitch_ff, pitch_in;
   logic [SW-1:0]          trans_ff, trans_in;
   logic                   set_edge_ff, set_edge_in;
   logic [SW-1:0]          set_note_ff, set_note_in;
   logic [DW-1:0]          res_ff, res_in;
   logic [DW-1:0]          up_idx_ff, up_idx_in;
   logic [DW-1:0]          dn_idx_ff, dn_idx_in;
   logic [DW-1:0]          step_ff, step_in;
   logic                   up_hit_ff, up_hit_in;
   logic                   dn_hit_ff, dn_hit_in;
   logic [DW-1:0]          up_dist_ff, up_dist_in;
   logic [DW-1:0]          dn_dist_ff, dn_dist_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sqs_pkg::note_type      rsp_note_ff, rsp_note_in;
   logic                   rsp_gate_ff, rsp_gate_in;
   logic                   rsp_chg_ff, rsp_chg_in;
   logic [TW-1:0]          rsp_scale_ff, rsp_scale_in;

   sqs_pkg::opnd_type      mod_operand;
   logic [DW-1:0]          mod_degree;
   logic [DEGREES-1:0]     toggle_ext;
   logic [TW-1:0]          scale_view;
   logic                   req_beat;
   logic                   rsp_load;
   logic                   up_hit_now;
   logic                   dn_hit_now;
   logic                   in_scale;
   logic                   mode_ok;
   logic                   hold;
   sqs_pkg::note_type      pitch_ext;
   sqs_pkg::note_type      trans_ext;
   sqs_pkg::note_type      note_q;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_beat   = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign pitch_ext  = {pitch_ff[SW-1], pitch_ff};
   assign trans_ext  = {trans_ff[SW-1], trans_ff};

   // Fit the fixed-width toggle field to the scale width, and the scale mask to the response width
   for (genvar i = 0; i < DEGREES; i++) begin : g_tog
      if (i < TW) begin : g_in
         assign toggle_ext[i] = req_button_toggles[i];
      end else begin : g_zero
         assign toggle_ext[i] = 1'b0;
      end
   end
   for (genvar j = 0; j < TW; j++) begin : g_view
      if (j < DEGREES) begin : g_in
         assign scale_view[j] = mask_ff[j];
      end else begin : g_zero
         assign scale_view[j] = 1'b0;
      end
   end

   // Select the operand of the shared modulo unit by sequencer step
   always_comb begin
      case (state_ff)
         S_SETD:  mod_operand = OW'({set_note_ff[SW-1], set_note_ff});
         S_SETT:  mod_operand = OW'(NW'(res_ff) - (nst_ff ? trans_ext : '0));
         S_PD:    mod_operand = OW'(pitch_ext);
         S_TMP:   mod_operand = OW'(NW'(res_ff) - trans_ext);
         default: mod_operand = '0;
      endcase
   end

   sqs_mod_unit #(
      .DEGREES (DEGREES)
   ) u_mod (
      .operand (mod_operand),
      .degree  (mod_degree)
   );

   // Search hits and final note selection
   assign up_hit_now = up_hit_ff || mask_ff[up_idx_ff];
   assign dn_hit_now = dn_hit_ff || mask_ff[dn_idx_ff];
   assign in_scale   = up_hit_ff && (up_dist_ff == '0);
   assign mode_ok    = mode_ff inside {[sqs_pkg::MODE_CLOSE_UP : sqs_pkg::MODE_DOWN]};
   assign hold       = !in_scale && (!mode_ok || (mask_ff == '0));

   always_comb begin
      case (mode_ff)
         sqs_pkg::MODE_CLOSE_UP:
            note_q = (up_dist_ff > dn_dist_ff) ? pitch_ext - NW'(dn_dist_ff)
                                               : pitch_ext + NW'(up_dist_ff);
         sqs_pkg::MODE_CLOSE_DN:
            note_q = (dn_dist_ff > up_dist_ff) ? pitch_ext + NW'(up_dist_ff)
                                               : pitch_ext - NW'(dn_dist_ff);
         sqs_pkg::MODE_UP:   note_q = pitch_ext + NW'(up_dist_ff);
         sqs_pkg::MODE_DOWN: note_q = pitch_ext - NW'(dn_dist_ff);
         default:            note_q = pitch_ext;
      endcase
      if (in_scale) begin
         note_q = pitch_ext;
      end
   end

   // Next-state logic for the sequencer and datapath registers
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      nst_in       = nst_ff;
      mask_in      = mask_ff;
      last_in      = last_ff;
      pitch_in     = pitch_ff;
      trans_in     = trans_ff;
      set_edge_in  = set_edge_ff;
      set_note_in  = set_note_ff;
      res_in       = res_ff;
      up_idx_in    = up_idx_ff;
      dn_idx_in    = dn_idx_ff;
      step_in      = step_ff;
      up_hit_in    = up_hit_ff;
      dn_hit_in    = dn_hit_ff;
      up_dist_in   = up_dist_ff;
      dn_dist_in   = dn_dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_note_in  = rsp_note_ff;
      rsp_gate_in  = rsp_gate_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_scale_in = rsp_scale_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            sqs_pkg::CSR_MODE: mode_in = csr_data;
            sqs_pkg::CSR_NST:  nst_in  = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            // Apply toggles, then the reset edge, and hold the beat
            if (req_beat) begin
               mask_in     = mask_ff ^ toggle_ext;
               if (req_reset_edge) begin
                  mask_in = '0;
                  last_in = '0;
               end
               pitch_in    = req_pitch_semis;
               trans_in    = req_transpose_semis;
               set_edge_in = req_set_edge;
               set_note_in = req_set_note_semis;
               state_in    = S_SETD;
            end
         end
         S_SETD: begin
            res_in   = mod_degree;
            state_in = S_SETT;
         end
         S_SETT: begin
            if (set_edge_ff) begin
               mask_in[mod_degree] = ~mask_ff[mod_degree];
            end
            state_in = S_PD;
         end
         S_PD: begin
            res_in   = mod_degree;
            state_in = S_TMP;
         end
         S_TMP: begin
            up_idx_in = mod_degree;
            dn_idx_in = mod_degree;
            step_in   = '0;
            up_hit_in = 1'b0;
            dn_hit_in = 1'b0;
            state_in  = S_SRCH;
         end
         S_SRCH: begin
            // One degree up and one down each cycle; keep the first hit in each direction
            if (!up_hit_ff && mask_ff[up_idx_ff]) begin
               up_dist_in = step_ff;
            end
            if (!dn_hit_ff && mask_ff[dn_idx_ff]) begin
               dn_dist_in = step_ff;
            end
            up_hit_in = up_hit_now;
            dn_hit_in = dn_hit_now;
            up_idx_in = (up_idx_ff == DW'(DEGREES - 1)) ? '0 : up_idx_ff + DW'(1);
            dn_idx_in = (dn_idx_ff == '0) ? DW'(DEGREES - 1) : dn_idx_ff - DW'(1);
            step_in   = step_ff + DW'(1);
            if ((up_hit_now && dn_hit_now) || (step_ff == DW'(DEGREES - 1))) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Load the response register once it is free
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_scale_in = scale_view;
               if (hold) begin
                  rsp_note_in = last_ff;
                  rsp_gate_in = 1'b0;
                  rsp_chg_in  = 1'b0;
               end else begin
                  rsp_note_in = note_q;
                  rsp_gate_in = 1'b1;
                  rsp_chg_in  = (note_q != last_ff);
                  last_in     = note_q;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= sqs_pkg::MODE_CLOSE_UP;
         nst_ff       <= 1'b1;
         mask_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         nst_ff       <= nst_in;
         mask_ff      <= mask_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and search registers
   always_ff @(posedge clock) begin
      pitch_ff     <= pitch_in;
      trans_ff     <= trans_in;
      set_edge_ff  <= set_edge_in;
      set_note_ff  <= set_note_in;
      res_ff       <= res_in;
      up_idx_ff    <= up_idx_in;
      dn_idx_ff    <= dn_idx_in;
      step_ff      <= step_in;
      up_hit_ff    <= up_hit_in;
      dn_hit_ff    <= dn_hit_in;
      up_dist_ff   <= up_dist_in;
      dn_dist_ff   <= dn_dist_in;
      rsp_note_ff  <= rsp_note_in;
      rsp_gate_ff  <= rsp_gate_in;
      rsp_chg_ff   <= rsp_chg_in;
      rsp_scale_ff <= rsp_scale_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_note_out     = rsp_note_ff;
   assign rsp_gate_on      = rsp_gate_ff;
   assign rsp_note_changed = rsp_chg_ff;
   assign rsp_scale_now    = rsp_scale_ff;

   // Checks
   `SQS_ASSERT_IMP(a_idx_range, clock, reset, state_ff == S_SRCH,
      (int'(up_idx_ff) < DEGREES) && (int'(dn_idx_ff) < DEGREES))
   `SQS_ASSERT_IMP(a_held_unchanged, clock, reset, rsp_valid && !rsp_gate_on,
      !rsp_note_changed)
   `SQS_ASSERT_NXT(a_last_tracks_out, clock, reset, rsp_load, rsp_note_out == last_ff)
   `SQS_ASSERT_NXT(a_beat_starts, clock, reset, req_beat, state_ff == S_SETD)

endmodule
